[rtl/hpsm_pkg.sv]
// ----------------------------------------------------------------------------
// hpsm_pkg
// Shared types, codes and header templates for the program stream muxer.
// ----------------------------------------------------------------------------
package hpsm_pkg;

    // request codes
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    // NAL classes
    localparam logic [2:0] CLASS_SPS   = 3'd0;
    localparam logic [2:0] CLASS_PPS   = 3'd1;
    localparam logic [2:0] CLASS_IDR   = 3'd2;
    localparam logic [2:0] CLASS_P     = 3'd3;
    localparam logic [2:0] CLASS_OTHER = 3'd4;

    localparam logic [15:0] MAX_PES_PAYLOAD = 16'd65522;
    localparam logic [15:0] PES_LEN_OFS     = 16'd13;
    localparam logic [6:0]  SCR_DIVISOR     = 7'd100;
    // ceil(2^19 / 100); exact digit quotient for any 15-bit partial value below 25600
    localparam logic [12:0] SCR_RECIP       = 13'd5243;

    // last word index of each burst, and the index of the first SCR byte
    localparam logic [5:0] PACK_LAST_IDX = 6'd13;
    localparam logic [5:0] SPS_LAST_IDX  = 6'd55;
    localparam logic [5:0] PES_LAST_IDX  = 6'd19;
    localparam logic [5:0] BYTE_LAST_IDX = 6'd0;
    localparam logic [5:0] SCR_FIRST_IDX = 6'd4;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  nal_class;
        logic [47:0] clock_value;
        logic [23:0] frame_length;
        logic [7:0]  payload_byte;
    } req_word_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       run_last;
    } res_word_t;

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_PACK,
        JOB_SPS,
        JOB_PES,
        JOB_BYTE
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [47:0] clock;
        logic [15:0] chunk;
        logic [7:0]  data;
    } job_t;

    typedef struct packed {
        logic        done;
        logic [32:0] base;
        logic [6:0]  ext;
    } scr_t;

    typedef logic [0:13][7:0] pack_hdr_t;
    typedef logic [0:55][7:0] sps_hdr_t;
    typedef logic [0:18][7:0] pes_hdr_t;

    localparam logic [143:0] SYS_HDR = {
        32'h000001BB, 16'd12, 1'b1, 22'd50000, 1'b1, 6'd1, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b1, 5'd1, 1'b0, 7'h7F,
        8'hC0, 2'b11, 1'b0, 13'd512,
        8'hE0, 2'b11, 1'b1, 13'd2048
    };

    // CRC field is fixed
    localparam logic [191:0] MAP_HDR = {
        24'h000001, 8'hBC, 16'd18, 1'b1, 2'b11, 5'd0, 7'h7F, 1'b1,
        16'd0, 16'd8, 8'h90, 8'hC0, 16'd0,
        8'h1B, 8'hE0, 16'd0,
        8'h45, 8'hBD, 8'hDC, 8'hF4
    };

    function automatic pack_hdr_t pack_hdr(input logic [32:0] base, input logic [8:0] ext);
        pack_hdr = {32'h000001BA, 2'b01, base[32:30], 1'b1, base[29:15], 1'b1,
                    base[14:0], 1'b1, ext, 1'b1, 22'd255, 2'b11, 5'h1F, 3'b000};
    endfunction

    function automatic logic [39:0] stamp(input logic [3:0] prefix, input logic [32:0] ts);
        stamp = {prefix, ts[32:30], 1'b1, ts[29:15], 1'b1, ts[14:0], 1'b1};
    endfunction

    function automatic pes_hdr_t pes_hdr(input logic [15:0] chunk, input logic [32:0] ts);
        pes_hdr = {24'h000001, 8'hE0, 16'(chunk + PES_LEN_OFS), 2'b10, 6'd0,
                   2'b11, 6'd0, 8'd10, stamp(4'd3, ts), stamp(4'd1, ts)};
    endfunction

endpackage

[rtl/hpsm_frame_ctl.sv]
// ----------------------------------------------------------------------------
// hpsm_frame_ctl
// Frame and chunk bookkeeping; turns each request word into a burst job.
// ----------------------------------------------------------------------------
module hpsm_frame_ctl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  hpsm_pkg::req_word_t req_word,
    output hpsm_pkg::job_t     job
);

    logic [2:0]  class_reg,       class_next;
    logic [23:0] frame_left_reg,  frame_left_next;
    logic [15:0] chunk_left_reg,  chunk_left_next;
    logic [47:0] saved_clock_reg, saved_clock_next;

    logic [2:0]  cls;
    logic [15:0] chunk;

    always_comb
    begin
        class_next       = class_reg;
        frame_left_next  = frame_left_reg;
        chunk_left_next  = chunk_left_reg;
        saved_clock_next = saved_clock_reg;
        job.kind         = hpsm_pkg::JOB_NONE;
        job.clock        = saved_clock_reg;
        job.chunk        = 16'd0;
        job.data         = req_word.payload_byte;

        cls = (req_word.nal_class > hpsm_pkg::CLASS_OTHER) ? hpsm_pkg::CLASS_OTHER
                                                            : req_word.nal_class;
        chunk = (frame_left_reg > 24'(hpsm_pkg::MAX_PES_PAYLOAD))
                ? hpsm_pkg::MAX_PES_PAYLOAD : frame_left_reg[15:0];

        if (req_word.req_type == hpsm_pkg::REQ_FRAME)
        begin
            class_next       = cls;
            frame_left_next  = req_word.frame_length;
            chunk_left_next  = 16'd0;
            saved_clock_next = req_word.clock_value;
            job.clock        = req_word.clock_value;
            case (cls)
                hpsm_pkg::CLASS_SPS: job.kind = hpsm_pkg::JOB_SPS;
                hpsm_pkg::CLASS_P:   job.kind = hpsm_pkg::JOB_PACK;
                default:             job.kind = hpsm_pkg::JOB_NONE;
            endcase
        end
        else if (class_reg != hpsm_pkg::CLASS_OTHER && frame_left_reg != 24'd0)
        begin
            frame_left_next = frame_left_reg - 24'd1;
            if (chunk_left_reg == 16'd0)
            begin
                job.kind        = hpsm_pkg::JOB_PES;
                job.chunk       = chunk;
                chunk_left_next = chunk - 16'd1;
            end
            else
            begin
                job.kind        = hpsm_pkg::JOB_BYTE;
                chunk_left_next = chunk_left_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg       <= hpsm_pkg::CLASS_OTHER;
            frame_left_reg  <= 24'd0;
            chunk_left_reg  <= 16'd0;
            saved_clock_reg <= 48'd0;
        end
        else if (take)
        begin
            class_reg       <= class_next;
            frame_left_reg  <= frame_left_next;
            chunk_left_reg  <= chunk_left_next;
            saved_clock_reg <= saved_clock_next;
        end
    end

endmodule

[rtl/hpsm_scr_div.sv]
// ----------------------------------------------------------------------------
// hpsm_scr_div
// Divides the 48-bit time by 100, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module hpsm_scr_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [47:0]        dividend,
    output hpsm_pkg::scr_t     scr
);

    logic [47:0] dvd_reg, dvd_next;
    logic [6:0]  rem_reg, rem_next;
    logic [2:0]  cnt_reg, cnt_next;

    // long division in base 256; each digit from a reciprocal multiply.
    // dvd_reg ends up holding the quotient
    always_comb
    begin
        logic [14:0] part;
        logic [27:0] prod;
        logic [7:0]  qd;
        logic [14:0] back;
        logic [6:0]  r;
        logic [47:0] d;
        part = {rem_reg, dvd_reg[47:40]};
        prod = 28'(part) * 28'(hpsm_pkg::SCR_RECIP);
        qd   = prod[26:19];
        back = 15'(qd) * 15'(hpsm_pkg::SCR_DIVISOR);
        r    = 7'(part - back);
        d    = {dvd_reg[39:0], qd};

        if (start)
        begin
            dvd_next = dividend;
            rem_next = 7'd0;
            cnt_next = 3'd6;
        end
        else if (cnt_reg != 3'd0)
        begin
            dvd_next = d;
            rem_next = r;
            cnt_next = cnt_reg - 3'd1;
        end
        else
        begin
            dvd_next = dvd_reg;
            rem_next = rem_reg;
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign scr.done = (cnt_reg == 3'd0);
    assign scr.base = dvd_reg[32:0];
    assign scr.ext  = rem_reg;

endmodule

[rtl/hpsm_byte_gen.sv]
// ----------------------------------------------------------------------------
// hpsm_byte_gen
// Holds the current burst job; plays it out one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module hpsm_byte_gen
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hpsm_pkg::job_t      job_in,
    input  hpsm_pkg::scr_t      scr,
    output logic                ready,
    output logic                ps_valid,
    input  logic                ps_ready,
    output hpsm_pkg::res_word_t ps_word
);

    hpsm_pkg::job_t      job_reg;
    logic                jv_reg,  jv_next;
    logic [5:0]          idx_reg, idx_next;
    logic                ps_valid_reg, ps_valid_next;
    hpsm_pkg::res_word_t ps_word_reg,  ps_word_next;

    hpsm_pkg::pack_hdr_t pack;
    hpsm_pkg::sps_hdr_t  sps;
    hpsm_pkg::pes_hdr_t  pes;
    logic [5:0]          last_idx;
    logic [7:0]          cur_byte;
    logic                need_scr, out_free, emit, last;

    always_comb
    begin
        pack = hpsm_pkg::pack_hdr(scr.base, {2'b00, scr.ext});
        sps  = {pack, hpsm_pkg::SYS_HDR, hpsm_pkg::MAP_HDR};
        pes  = hpsm_pkg::pes_hdr(job_reg.chunk, job_reg.clock[32:0]);

        unique case (job_reg.kind)
            hpsm_pkg::JOB_PACK:
            begin
                last_idx = hpsm_pkg::PACK_LAST_IDX;
                cur_byte = pack[idx_reg[3:0]];
            end
            hpsm_pkg::JOB_SPS:
            begin
                last_idx = hpsm_pkg::SPS_LAST_IDX;
                cur_byte = sps[idx_reg];
            end
            hpsm_pkg::JOB_PES:
            begin
                last_idx = hpsm_pkg::PES_LAST_IDX;
                cur_byte = (idx_reg == hpsm_pkg::PES_LAST_IDX) ? job_reg.data
                                                                : pes[idx_reg[4:0]];
            end
            default:
            begin
                last_idx = hpsm_pkg::BYTE_LAST_IDX;
                cur_byte = job_reg.data;
            end
        endcase

        // SCR bytes wait for the divider
        need_scr = (job_reg.kind == hpsm_pkg::JOB_PACK || job_reg.kind == hpsm_pkg::JOB_SPS)
                   && (idx_reg >= hpsm_pkg::SCR_FIRST_IDX);
        out_free = !ps_valid_reg || ps_ready;
        emit     = jv_reg && out_free && (!need_scr || scr.done);
        last     = (idx_reg == last_idx);
        ready    = !jv_reg || (emit && last);

        if (load)
        begin
            jv_next  = (job_in.kind != hpsm_pkg::JOB_NONE);
            idx_next = 6'd0;
        end
        else if (emit)
        begin
            jv_next  = !last && jv_reg;
            idx_next = idx_reg + 6'd1;
        end
        else
        begin
            jv_next  = jv_reg;
            idx_next = idx_reg;
        end

        if (emit)
        begin
            ps_valid_next            = 1'b1;
            ps_word_next.stream_byte = cur_byte;
            ps_word_next.run_last    = last;
        end
        else
        begin
            ps_valid_next = ps_valid_reg && !ps_ready;
            ps_word_next  = ps_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg       <= 1'b0;
            idx_reg      <= 6'd0;
            ps_valid_reg <= 1'b0;
        end
        else
        begin
            jv_reg       <= jv_next;
            idx_reg      <= idx_next;
            ps_valid_reg <= ps_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        ps_word_reg <= ps_word_next;
    end

    assign ps_valid = ps_valid_reg;
    assign ps_word  = ps_word_reg;

endmodule

[rtl/h264_program_stream_muxer.sv]
// ----------------------------------------------------------------------------
// h264_program_stream_muxer
// Wraps H.264 NAL units into an MPEG-2 program stream, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_*) carry either a frame start (class, time, length)
//   or one payload byte. Stream words (ps_*) carry one output byte each,
//   with run_last set on the final byte caused by a request.
//   A request is taken in a cycle its job register is free or sends its
//   last byte; its job register is loaded and the first byte then passes
//   through the output register. A payload byte gives one output byte, or
//   the PES header plus the byte when it opens a chunk; a P frame start
//   gives a pack header and an SPS start the pack, system and map headers.
//   The pack SCR comes from a divide-by-100 unit started with the frame
//   start; the first SCR byte waits on it. Requests that give no output
//   (PPS, IDR, dropped or stray bytes) pass once the job register is free.
//   A stalled receiver holds the output register; the job behind it waits
//   and request ready drops once the current burst cannot finish.
//   Reset empties the job and output registers and leaves no frame open.
// ----------------------------------------------------------------------------
module h264_program_stream_muxer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  hpsm_pkg::req_word_t req_word,
    output logic                ps_valid,
    input  logic                ps_ready,
    output hpsm_pkg::res_word_t ps_word
);

    hpsm_pkg::job_t job;
    hpsm_pkg::scr_t scr;
    logic           take;
    logic           div_start;

    assign take = req_valid && req_ready;

    // SCR divide runs alongside the constant start code bytes
    assign div_start = take && (job.kind == hpsm_pkg::JOB_PACK ||
                                job.kind == hpsm_pkg::JOB_SPS);

    hpsm_frame_ctl u_frame_ctl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .req_word (req_word),
        .job      (job)
    );

    hpsm_scr_div u_scr_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (job.clock),
        .scr      (scr)
    );

    hpsm_byte_gen u_byte_gen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .job_in   (job),
        .scr      (scr),
        .ready    (req_ready),
        .ps_valid (ps_valid),
        .ps_ready (ps_ready),
        .ps_word  (ps_word)
    );

endmodule
